// ----- hdl/triangle_span_generator_top_defines.svh -----
// Assertion macros shared by the triangle span generator sources.
`ifndef TRIANGLE_SPAN_GENERATOR_TOP_DEFINES_SVH
`define TRIANGLE_SPAN_GENERATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSG_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tsg_pkg.sv -----
// Shared constants, types and codes of the triangle span generator.
`default_nettype none
package tsg_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int SLOPE_DY_LIMIT = 4096;
   localparam int DIV_W          = $clog2(SLOPE_DY_LIMIT);
   localparam int NUM_W          = 31;
   localparam int CNT_W          = $clog2(NUM_W);

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ROW_STRIDE    = 2'd2;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_STEP   = 1'b1;
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_SPAN = 1'b1;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CHECK = 10'b0000000010,
      S_AREA1 = 10'b0000000100,
      S_AREA2 = 10'b0000001000,
      S_DIV   = 10'b0000010000,
      S_CLIPA = 10'b0000100000,
      S_CLIPB = 10'b0001000000,
      S_CLIPC = 10'b0010000000,
      S_FIN   = 10'b0100000000,
      S_SPAN  = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
      logic             neg;
      logic             zero;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ----- hdl/tsg_div.sv -----
// Restoring divider for edge slopes, one quotient bit per cycle.
`default_nettype none
module tsg_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsg_pkg::div_req_type div_req,
   output tsg_pkg::div_rsp_type      div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [tsg_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [tsg_pkg::DIV_W-1:0]    rem_ff, rem_in;
   logic [tsg_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [tsg_pkg::DIV_W-1:0]    dvs_ff, dvs_in;
   logic                         neg_ff, neg_in;
   logic                         zero_ff, zero_in;
   logic [tsg_pkg::DIV_W:0]      shifted;
   logic [tsg_pkg::DIV_W+1:0]    diff;
   logic                         qbit;
   logic [31:0]                  mag;

   always_comb begin
      shifted = {rem_ff, quo_ff[tsg_pkg::NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      qbit    = ~diff[tsg_pkg::DIV_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = tsg_pkg::CNT_W'(tsg_pkg::NUM_W - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         neg_in  = div_req.neg;
         zero_in = div_req.zero;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[tsg_pkg::DIV_W-1:0] : shifted[tsg_pkg::DIV_W-1:0];
         quo_in = {quo_ff[tsg_pkg::NUM_W-2:0], qbit};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign mag = {1'b0, quo_ff};
   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = zero_ff ? 32'd0 : (neg_ff ? (32'd0 - mag) : mag);

endmodule
`default_nettype wire

// ----- hdl/triangle_span_generator_top.sv -----
// Triangle span generator: setup sequencer, row walker and output register.
//
// The request channel carries one item per beat: operation 0 loads a triangle
// from the three vertex fields, operation 1 asks for the next row span. Every
// request gives exactly one response beat: a load report (kind 0) or a span
// (kind 1). A request is taken when req_valid is high and req_stall low.
// A step passes through the span state and then the response register. A
// load that survives the early checks is dominated by three slope
// divisions in the bit-serial divider; a load that is rejected on its rows
// answers from the row check, and one with zero area from the area check.
// The block works on one request at a time and holds req_stall high meanwhile.
// The response sits in a register until taken; while rsp_stall holds it, the
// block takes no new request. csr_ready is always high; the user is to write
// registers only while the block is idle (not enforced). Synchronous reset
// restores the register defaults of 512 and leaves no triangle active.
`default_nettype none
`include "triangle_span_generator_top_defines.svh"
module triangle_span_generator_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire logic signed [14:0] req_vx_a,
   input  wire logic signed [14:0] req_vx_b,
   input  wire logic signed [14:0] req_vx_c,
   input  wire logic signed [12:0] req_vy_a,
   input  wire logic signed [12:0] req_vy_b,
   input  wire logic signed [12:0] req_vy_c,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_kind,
   output logic                    rsp_accepted,
   output logic                    rsp_row_valid,
   output logic [11:0]             rsp_row,
   output logic                    rsp_span_nonempty,
   output logic [11:0]             rsp_x_first,
   output logic [11:0]             rsp_x_end,
   output logic [24:0]             rsp_pixel_address,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [13:0]        csr_data
);

   tsg_pkg::state_type state_ff, state_in;

   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [13:0] stride_ff, stride_in;

   logic signed [14:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [12:0] y0_ff, y0_in, y1_ff, y1_in, y2_ff, y2_in;
   logic [31:0] prod_ff, prod_in;
   logic [1:0]  div_idx_ff, div_idx_in;
   logic        div_go_ff, div_go_in;

   logic [31:0] long_pos_ff, long_pos_in;
   logic [31:0] short_pos_ff, short_pos_in;
   logic [31:0] long_step_ff, long_step_in;
   logic [31:0] upper_step_ff, upper_step_in;
   logic [31:0] lower_step_ff, lower_step_in;
   logic [31:0] lower_start_ff, lower_start_in;
   logic [12:0] upper_left_ff, upper_left_in;
   logic [12:0] lower_left_ff, lower_left_in;
   logic [11:0] row_ff, row_in;
   logic        long_right_ff, long_right_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic        rsp_accepted_ff, rsp_accepted_in;
   logic        rsp_row_valid_ff, rsp_row_valid_in;
   logic [11:0] rsp_row_ff, rsp_row_in;
   logic        rsp_nonempty_ff, rsp_nonempty_in;
   logic [11:0] rsp_x_first_ff, rsp_x_first_in;
   logic [11:0] rsp_x_end_ff, rsp_x_end_in;
   logic [24:0] rsp_addr_ff, rsp_addr_in;
   logic        rsp_last_ff, rsp_last_in;

   logic req_accept;
   logic signed [14:0] sx0, sx1, sx2;
   logic signed [12:0] sy0, sy1, sy2;

   logic signed [15:0] dx10, dx20, dx21, div_dx;
   logic signed [13:0] dy10, dy20, dy21, div_dy;
   logic [15:0] dx_mag;

   logic signed [31:0] mul_a;
   logic signed [14:0] mul_b;
   logic signed [46:0] mul_full;
   logic [31:0] mul_p;

   tsg_pkg::div_req_type div_req;
   tsg_pkg::div_rsp_type div_rsp;

   logic signed [13:0] hs, hm1, y0c, y1c, y1f, y2f;
   logic signed [14:0] up_s, lo_s;
   logic [12:0] up_c, lo_c;
   logic fin_right;

   logic active;
   logic [31:0] sp_start, sp_end;
   logic signed [16:0] ws, xe_raw, xs_raw, xe, xs;
   logic sp_nonempty;
   logic [12:0] sp_first;
   logic [11:0] sp_stop;
   logic [12:0] up_next, lo_next;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != tsg_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign csr_ready  = 1'b1;

   // Vertex ordering by y; ties keep the earlier vertex on top, but c goes above a on a tie when b is on top.
   always_comb begin
      if (req_vy_a <= req_vy_b && req_vy_a <= req_vy_c) begin
         sx0 = req_vx_a; sy0 = req_vy_a;
         if (req_vy_b <= req_vy_c) begin
            sx1 = req_vx_b; sy1 = req_vy_b; sx2 = req_vx_c; sy2 = req_vy_c;
         end else begin
            sx1 = req_vx_c; sy1 = req_vy_c; sx2 = req_vx_b; sy2 = req_vy_b;
         end
      end else if (req_vy_b <= req_vy_c) begin
         sx0 = req_vx_b; sy0 = req_vy_b;
         if (req_vy_c <= req_vy_a) begin
            sx1 = req_vx_c; sy1 = req_vy_c; sx2 = req_vx_a; sy2 = req_vy_a;
         end else begin
            sx1 = req_vx_a; sy1 = req_vy_a; sx2 = req_vx_c; sy2 = req_vy_c;
         end
      end else begin
         sx0 = req_vx_c; sy0 = req_vy_c;
         if (req_vy_a <= req_vy_b) begin
            sx1 = req_vx_a; sy1 = req_vy_a; sx2 = req_vx_b; sy2 = req_vy_b;
         end else begin
            sx1 = req_vx_b; sy1 = req_vy_b; sx2 = req_vx_a; sy2 = req_vy_a;
         end
      end
   end

   assign dx10 = {x1_ff[14], x1_ff} - {x0_ff[14], x0_ff};
   assign dx20 = {x2_ff[14], x2_ff} - {x0_ff[14], x0_ff};
   assign dx21 = {x2_ff[14], x2_ff} - {x1_ff[14], x1_ff};
   assign dy10 = {y1_ff[12], y1_ff} - {y0_ff[12], y0_ff};
   assign dy20 = {y2_ff[12], y2_ff} - {y0_ff[12], y0_ff};
   assign dy21 = {y2_ff[12], y2_ff} - {y1_ff[12], y1_ff};

   // Divider operands: long edge, upper edge, then lower edge.
   always_comb begin
      case (div_idx_ff)
         2'd0:    begin div_dx = dx20; div_dy = dy20; end
         2'd1:    begin div_dx = dx10; div_dy = dy10; end
         default: begin div_dx = dx21; div_dy = dy21; end
      endcase
      dx_mag = div_dx[15] ? (16'd0 - div_dx) : div_dx;
      div_req.start    = (state_ff == tsg_pkg::S_DIV) && div_go_ff;
      div_req.dividend = {dx_mag[14:0], 16'd0};
      div_req.divisor  = div_dy[tsg_pkg::DIV_W-1:0];
      div_req.neg      = div_dx[15];
      div_req.zero     = (div_dy <= 14'sd0) ||
                         ($signed({div_dy[13], div_dy}) >=
                          15'(tsg_pkg::SLOPE_DY_LIMIT));
   end

   tsg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The one shared multiplier: area terms, clip offsets and row base address.
   always_comb begin
      case (state_ff)
         tsg_pkg::S_AREA1: begin
            mul_a = 32'(dx10); mul_b = 15'(dy20);
         end
         tsg_pkg::S_AREA2: begin
            mul_a = 32'(dx20); mul_b = 15'(dy10);
         end
         tsg_pkg::S_CLIPA: begin
            mul_a = long_step_ff;
            mul_b = y0_ff[12] ? 15'(y0_ff) : 15'sd0;
         end
         tsg_pkg::S_CLIPB: begin
            mul_a = upper_step_ff;
            mul_b = y0_ff[12] ? 15'(y0_ff) : 15'sd0;
         end
         tsg_pkg::S_CLIPC: begin
            mul_a = lower_step_ff;
            mul_b = y1_ff[12] ? 15'(y1_ff) : 15'sd0;
         end
         tsg_pkg::S_SPAN: begin
            mul_a = {20'd0, row_ff}; mul_b = {1'b0, stride_ff};
         end
         default: begin
            mul_a = 32'sd0; mul_b = 15'sd0;
         end
      endcase
   end
   assign mul_full = mul_a * mul_b;
   assign mul_p    = mul_full[31:0];

   // Final row clamping and choice of the right-hand edge.
   always_comb begin
      hs   = $signed({1'b0, height_ff});
      hm1  = hs - 14'sd1;
      y0c  = y0_ff[12] ? 14'sd0 : {y0_ff[12], y0_ff};
      y1c  = y1_ff[12] ? 14'sd0 : {y1_ff[12], y1_ff};
      y1f  = y1c;
      y2f  = {y2_ff[12], y2_ff};
      if (y1c >= hs) begin
         y1f = hm1;
         y2f = hm1;
      end else if (y2f >= hs) begin
         y2f = hm1;
      end
      up_s = {y1f[13], y1f} - {y0c[13], y0c};
      lo_s = {y2f[13], y2f} - {y1f[13], y1f};
      up_c = up_s[14] ? 13'd0 : up_s[12:0];
      lo_c = lo_s[14] ? 13'd0 : lo_s[12:0];
      fin_right = (y0c == y1f) ? ($signed(long_step_ff) <= $signed(lower_step_ff))
                               : ($signed(long_step_ff) >= $signed(upper_step_ff));
   end

   // Span of the current row between the two active edges.
   always_comb begin
      active   = (upper_left_ff != '0) || (lower_left_ff != '0);
      sp_start = long_right_ff ? short_pos_ff : long_pos_ff;
      sp_end   = long_right_ff ? long_pos_ff : short_pos_ff;
      ws       = $signed({4'd0, width_ff});
      xe_raw   = {sp_end[31], sp_end[31:16]};
      xs_raw   = {sp_start[31], sp_start[31:16]};
      xe       = (xe_raw >= ws) ? (ws - 17'sd1) : xe_raw;
      xs       = xs_raw[16] ? 17'sd0 : xs_raw;
      sp_nonempty = (sp_start != sp_end) && (xs < xe);
      sp_first = sp_nonempty ? xs[12:0] : 13'd0;
      sp_stop  = sp_nonempty ? xe[11:0] : 12'd0;
      up_next  = upper_left_ff;
      lo_next  = lower_left_ff;
      if (upper_left_ff != '0) begin
         up_next = upper_left_ff - 1'b1;
      end else begin
         lo_next = lower_left_ff - 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      stride_in      = stride_ff;
      x0_in          = x0_ff;
      x1_in          = x1_ff;
      x2_in          = x2_ff;
      y0_in          = y0_ff;
      y1_in          = y1_ff;
      y2_in          = y2_ff;
      prod_in        = prod_ff;
      div_idx_in     = div_idx_ff;
      div_go_in      = 1'b0;
      long_pos_in    = long_pos_ff;
      short_pos_in   = short_pos_ff;
      long_step_in   = long_step_ff;
      upper_step_in  = upper_step_ff;
      lower_step_in  = lower_step_ff;
      lower_start_in = lower_start_ff;
      upper_left_in  = upper_left_ff;
      lower_left_in  = lower_left_ff;
      row_in         = row_ff;
      long_right_in  = long_right_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_kind_in      = rsp_kind_ff;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_row_valid_in = rsp_row_valid_ff;
      rsp_row_in       = rsp_row_ff;
      rsp_nonempty_in  = rsp_nonempty_ff;
      rsp_x_first_in   = rsp_x_first_ff;
      rsp_x_end_in     = rsp_x_end_ff;
      rsp_addr_in      = rsp_addr_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            tsg_pkg::CSR_SCREEN_WIDTH:  width_in  = csr_data[12:0];
            tsg_pkg::CSR_SCREEN_HEIGHT: height_in = csr_data[12:0];
            tsg_pkg::CSR_ROW_STRIDE:    stride_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         tsg_pkg::S_IDLE: begin
            if (req_accept) begin
               if (req_operation == tsg_pkg::OP_STEP) begin
                  state_in = tsg_pkg::S_SPAN;
               end else begin
                  x0_in = sx0; x1_in = sx1; x2_in = sx2;
                  y0_in = sy0; y1_in = sy1; y2_in = sy2;
                  upper_left_in = '0;
                  lower_left_in = '0;
                  state_in = tsg_pkg::S_CHECK;
               end
            end
         end
         tsg_pkg::S_CHECK: begin
            if (($signed({y0_ff[12], y0_ff}) >= $signed({1'b0, height_ff})) ||
                y2_ff[12] || (y2_ff == y0_ff)) begin
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = tsg_pkg::KIND_LOAD;
               rsp_accepted_in  = 1'b0;
               rsp_row_valid_in = 1'b0;
               rsp_row_in       = '0;
               rsp_nonempty_in  = 1'b0;
               rsp_x_first_in   = '0;
               rsp_x_end_in     = '0;
               rsp_addr_in      = '0;
               rsp_last_in      = 1'b0;
               state_in = tsg_pkg::S_IDLE;
            end else begin
               state_in = tsg_pkg::S_AREA1;
            end
         end
         tsg_pkg::S_AREA1: begin
            prod_in  = mul_p;
            state_in = tsg_pkg::S_AREA2;
         end
         tsg_pkg::S_AREA2: begin
            if (prod_ff == mul_p) begin
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = tsg_pkg::KIND_LOAD;
               rsp_accepted_in  = 1'b0;
               rsp_row_valid_in = 1'b0;
               rsp_row_in       = '0;
               rsp_nonempty_in  = 1'b0;
               rsp_x_first_in   = '0;
               rsp_x_end_in     = '0;
               rsp_addr_in      = '0;
               rsp_last_in      = 1'b0;
               state_in = tsg_pkg::S_IDLE;
            end else begin
               div_idx_in = 2'd0;
               div_go_in  = 1'b1;
               state_in   = tsg_pkg::S_DIV;
            end
         end
         tsg_pkg::S_DIV: begin
            if (div_rsp.done) begin
               case (div_idx_ff)
                  2'd0:    long_step_in  = div_rsp.quotient;
                  2'd1:    upper_step_in = div_rsp.quotient;
                  default: lower_step_in = div_rsp.quotient;
               endcase
               if (div_idx_ff == 2'd2) begin
                  long_pos_in    = {x0_ff[14], x0_ff, 16'd0};
                  short_pos_in   = {x0_ff[14], x0_ff, 16'd0};
                  lower_start_in = {x1_ff[14], x1_ff, 16'd0};
                  state_in       = tsg_pkg::S_CLIPA;
               end else begin
                  div_idx_in = div_idx_ff + 2'd1;
                  div_go_in  = 1'b1;
               end
            end
         end
         tsg_pkg::S_CLIPA: begin
            long_pos_in = long_pos_ff - mul_p;
            state_in    = tsg_pkg::S_CLIPB;
         end
         tsg_pkg::S_CLIPB: begin
            short_pos_in = short_pos_ff - mul_p;
            state_in     = tsg_pkg::S_CLIPC;
         end
         tsg_pkg::S_CLIPC: begin
            lower_start_in = lower_start_ff - mul_p;
            state_in       = tsg_pkg::S_FIN;
         end
         tsg_pkg::S_FIN: begin
            short_pos_in  = (up_c != '0) ? short_pos_ff : lower_start_ff;
            upper_left_in = up_c;
            lower_left_in = lo_c;
            row_in        = y0c[11:0];
            long_right_in = fin_right;
            rsp_valid_in     = 1'b1;
            rsp_kind_in      = tsg_pkg::KIND_LOAD;
            rsp_accepted_in  = (up_c != '0) || (lo_c != '0);
            rsp_row_valid_in = 1'b0;
            rsp_row_in       = '0;
            rsp_nonempty_in  = 1'b0;
            rsp_x_first_in   = '0;
            rsp_x_end_in     = '0;
            rsp_addr_in      = '0;
            rsp_last_in      = 1'b0;
            state_in = tsg_pkg::S_IDLE;
         end
         tsg_pkg::S_SPAN: begin
            rsp_valid_in    = 1'b1;
            rsp_kind_in     = tsg_pkg::KIND_SPAN;
            rsp_accepted_in = 1'b0;
            if (active) begin
               rsp_row_valid_in = 1'b1;
               rsp_row_in       = row_ff;
               rsp_nonempty_in  = sp_nonempty;
               rsp_x_first_in   = sp_first[11:0];
               rsp_x_end_in     = sp_stop;
               rsp_addr_in      = mul_p[24:0] + {12'd0, sp_first};
               rsp_last_in      = (up_next == '0) && (lo_next == '0);
               long_pos_in = long_pos_ff + long_step_ff;
               if (upper_left_ff != '0) begin
                  short_pos_in = (up_next == '0) ? lower_start_ff
                                                 : short_pos_ff + upper_step_ff;
               end else begin
                  short_pos_in = short_pos_ff + lower_step_ff;
               end
               upper_left_in = up_next;
               lower_left_in = lo_next;
               row_in        = row_ff + 12'd1;
            end else begin
               rsp_row_valid_in = 1'b0;
               rsp_row_in       = '0;
               rsp_nonempty_in  = 1'b0;
               rsp_x_first_in   = '0;
               rsp_x_end_in     = '0;
               rsp_addr_in      = '0;
               rsp_last_in      = 1'b0;
            end
            state_in = tsg_pkg::S_IDLE;
         end
         default: begin
            state_in = tsg_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tsg_pkg::S_IDLE;
         width_ff       <= 13'd512;
         height_ff      <= 13'd512;
         stride_ff      <= 14'd512;
         div_go_ff      <= 1'b0;
         long_pos_ff    <= '0;
         short_pos_ff   <= '0;
         long_step_ff   <= '0;
         upper_step_ff  <= '0;
         lower_step_ff  <= '0;
         lower_start_ff <= '0;
         upper_left_ff  <= '0;
         lower_left_ff  <= '0;
         row_ff         <= '0;
         long_right_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         stride_ff      <= stride_in;
         div_go_ff      <= div_go_in;
         long_pos_ff    <= long_pos_in;
         short_pos_ff   <= short_pos_in;
         long_step_ff   <= long_step_in;
         upper_step_ff  <= upper_step_in;
         lower_step_ff  <= lower_step_in;
         lower_start_ff <= lower_start_in;
         upper_left_ff  <= upper_left_in;
         lower_left_ff  <= lower_left_in;
         row_ff         <= row_in;
         long_right_ff  <= long_right_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      x0_ff            <= x0_in;
      x1_ff            <= x1_in;
      x2_ff            <= x2_in;
      y0_ff            <= y0_in;
      y1_ff            <= y1_in;
      y2_ff            <= y2_in;
      prod_ff          <= prod_in;
      div_idx_ff       <= div_idx_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_accepted_ff  <= rsp_accepted_in;
      rsp_row_valid_ff <= rsp_row_valid_in;
      rsp_row_ff       <= rsp_row_in;
      rsp_nonempty_ff  <= rsp_nonempty_in;
      rsp_x_first_ff   <= rsp_x_first_in;
      rsp_x_end_ff     <= rsp_x_end_in;
      rsp_addr_ff      <= rsp_addr_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_row_valid     = rsp_row_valid_ff;
   assign rsp_row           = rsp_row_ff;
   assign rsp_span_nonempty = rsp_nonempty_ff;
   assign rsp_x_first       = rsp_x_first_ff;
   assign rsp_x_end         = rsp_x_end_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_last          = rsp_last_ff;

   `TSG_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, (state_ff != tsg_pkg::S_IDLE) && !rsp_valid_ff, "request beat taken but sequencer did not start")
   `TSG_ASSERT_SAME(a_rsp_idle, rsp_valid_ff, state_ff == tsg_pkg::S_IDLE, "response held while sequencer busy")
   `TSG_ASSERT_SAME(a_div_state, div_rsp.busy, state_ff == tsg_pkg::S_DIV, "divider running outside slope setup")
   `TSG_ASSERT_SAME(a_last_done, rsp_valid_ff && rsp_last_ff, (upper_left_ff == '0) && (lower_left_ff == '0), "last row reported with rows left")

endmodule
`default_nettype wire
